@@ hdl/bds_pkg.sv @@
// Shared types and constants of the box filter downscaler.
// Used by every module of the block; depends on nothing.
package bds_pkg;

  localparam int CFG_W       = 13;
  localparam int CH_W        = 2;
  localparam int IDX_W       = 3;
  localparam int SAMPLE_W    = 8;
  localparam int COORD_W     = 12;
  localparam int SUM_W       = 32;
  localparam int QUO_W       = 8;
  localparam int STEP_W      = 3;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 48;
  localparam int OUT_CH      = 3;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_CHANNELS   = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Control from the sequencer to every channel lane
  typedef struct packed {
    logic              acc_en;
    logic              first;
    logic              div_en;
    logic [STEP_W-1:0] step;
  } lane_ctl_t;

endpackage

@@ hdl/bds_pos.sv @@
// Configuration registers, cell boundary setup and source/destination position tracking.
// Depends on bds_pkg.
module bds_pos #(
  parameter int MAX_WIDTH    = 4096,
  parameter int MAX_HEIGHT   = 4096,
  parameter int MAX_CHANNELS = 3,
  parameter int DW           = 13
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bds_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bds_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       adv,
  output logic                       busy,
  output logic                       first,
  output logic                       last,
  output logic                       frame_end,
  output logic [DW-1:0]              dst_col,
  output logic [DW-1:0]              dst_row,
  output logic [2*DW-1:0]            area,
  output logic [bds_pkg::CH_W-1:0]   ch
);
  import bds_pkg::*;

  localparam int CW    = (DW > CFG_W) ? DW : CFG_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic [CFG_W-1:0] src_width, src_height, dst_width, dst_height;
  logic [CH_W-1:0]  channel_count;

  // Clamp the raw register values
  logic [CW-1:0] sw_c, sh_c, dw_c, dh_c, swr_x, shr_x, dwr_x, dhr_x;
  logic [DW-1:0] sw, sh, dw, dh;
  logic [2:0]    ch_x;

  always_comb begin
    swr_x = CW'(src_width);
    shr_x = CW'(src_height);
    dwr_x = CW'(dst_width);
    dhr_x = CW'(dst_height);
    sw_c = (swr_x == '0) ? CW'(1) : ((swr_x > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : swr_x);
    sh_c = (shr_x == '0) ? CW'(1) : ((shr_x > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : shr_x);
    dw_c = (dwr_x == '0) ? CW'(1) : ((dwr_x > sw_c) ? sw_c : dwr_x);
    dh_c = (dhr_x == '0) ? CW'(1) : ((dhr_x > sh_c) ? sh_c : dhr_x);
    sw = sw_c[DW-1:0];
    sh = sh_c[DW-1:0];
    dw = dw_c[DW-1:0];
    dh = dh_c[DW-1:0];
    ch_x = 3'(channel_count);
    if (ch_x == 3'd0) begin
      ch = CH_W'(1);
    end else if (ch_x > 3'(MAX_CHANNELS)) begin
      ch = CH_W'(MAX_CHANNELS);
    end else begin
      ch = channel_count;
    end
  end

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width     <= CFG_W'(1);
      src_height    <= CFG_W'(1);
      dst_width     <= CFG_W'(1);
      dst_height    <= CFG_W'(1);
      channel_count <= CH_W'(3);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_width     <= cfg_data;
        REG_SRC_HEIGHT: src_height    <= cfg_data;
        REG_DST_WIDTH:  dst_width     <= cfg_data;
        REG_DST_HEIGHT: dst_height    <= cfg_data;
        REG_CHANNELS:   channel_count <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // Bit-serial dividers for source/destination (columns in slot 0, rows in slot 1)
  logic            start;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]   num [2];
  logic [DW-1:0]   den [2];
  logic [DW-1:0]   rem [2];
  logic [DW-1:0]   quo [2];
  logic [DW:0]     trial [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      trial[k] = {rem[k], num[k][DW-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num[0] <= sw;
      num[1] <= sh;
      den[0] <= dw;
      den[1] <= dh;
      rem[0] <= '0;
      rem[1] <= '0;
      quo[0] <= '0;
      quo[1] <= '0;
    end else if (cnt != '0) begin
      for (int k = 0; k < 2; k++) begin
        num[k] <= {num[k][DW-2:0], 1'b0};
        if (trial[k] >= (DW+1)'(den[k])) begin
          rem[k] <= DW'(trial[k] - (DW+1)'(den[k]));
          quo[k] <= {quo[k][DW-2:0], 1'b1};
        end else begin
          rem[k] <= trial[k][DW-1:0];
          quo[k] <= {quo[k][DW-2:0], 1'b0};
        end
      end
    end
  end

  // Sequence the setup divide after reset and after each register write
  always_ff @(posedge clk) begin
    if (rst) begin
      start <= 1'b1;
      busy  <= 1'b1;
      cnt   <= '0;
    end else if (cfg_valid) begin
      start <= 1'b1;
      busy  <= 1'b1;
      cnt   <= '0;
    end else if (start) begin
      start <= 1'b0;
      cnt   <= CNT_W'(DW);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end else if (busy) begin
      busy <= 1'b0;
    end
  end

  // Position state
  logic [DW-1:0] src_col, col_start, col_end, col_rem;
  logic [DW-1:0] src_row, row_start, row_end, row_rem;

  logic [DW-1:0] sc1, dc1, sr1, dr1, col_end_adv, row_end_adv;
  logic [DW:0]   csum, rsum;
  logic          col_hit, col_wrap, row_hit, row_wrap, cgo, rgo;

  always_comb begin
    sc1 = src_col + DW'(1);
    dc1 = dst_col + DW'(1);
    sr1 = src_row + DW'(1);
    dr1 = dst_row + DW'(1);
    csum = (DW+1)'(col_rem) + (DW+1)'(rem[0]);
    rsum = (DW+1)'(row_rem) + (DW+1)'(rem[1]);
    cgo = csum >= (DW+1)'(dw);
    rgo = rsum >= (DW+1)'(dh);
    col_end_adv = col_end + quo[0] + DW'(cgo);
    row_end_adv = row_end + quo[1] + DW'(rgo);
    col_hit  = sc1 >= col_end;
    col_wrap = (sc1 >= sw) || (col_hit && (dc1 >= dw));
    row_hit  = sr1 >= row_end;
    row_wrap = (sr1 >= sh) || (row_hit && (dr1 >= dh));
    first = (src_col == col_start) && (src_row == row_start);
    last  = (sc1 == col_end) && (sr1 == row_end);
    frame_end = (dc1 == dw) && (dr1 == dh);
    area = (2*DW)'(col_end - col_start) * (2*DW)'(row_end - row_start);
  end

  // Advance the position one source pixel, or restart the frame
  always_ff @(posedge clk) begin
    if (rst || (busy && !start && cnt == '0) || (adv && col_wrap && row_wrap)) begin
      src_col   <= '0;
      dst_col   <= '0;
      col_start <= '0;
      col_end   <= quo[0];
      col_rem   <= rem[0];
      src_row   <= '0;
      dst_row   <= '0;
      row_start <= '0;
      row_end   <= quo[1];
      row_rem   <= rem[1];
    end else if (adv) begin
      if (col_wrap) begin
        src_col   <= '0;
        dst_col   <= '0;
        col_start <= '0;
        col_end   <= quo[0];
        col_rem   <= rem[0];
        src_row   <= sr1;
        if (row_hit) begin
          dst_row   <= dr1;
          row_start <= row_end;
          row_end   <= row_end_adv;
          row_rem   <= rgo ? DW'(rsum - (DW+1)'(dh)) : rsum[DW-1:0];
        end
      end else begin
        src_col <= sc1;
        if (col_hit) begin
          dst_col   <= dc1;
          col_start <= col_end;
          col_end   <= col_end_adv;
          col_rem   <= cgo ? DW'(csum - (DW+1)'(dw)) : csum[DW-1:0];
        end
      end
    end
  end

endmodule

@@ hdl/bds_lane.sv @@
// One channel lane: accumulator line memory and an 8-step quotient unit.
// Depends on bds_pkg.
module bds_lane #(
  parameter int ADDR_W = 12,
  parameter int AREA_W = 26
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [ADDR_W-1:0]             rd_addr,
  input  logic [bds_pkg::SAMPLE_W-1:0]  sample,
  input  bds_pkg::lane_ctl_t            ctl,
  input  logic [AREA_W-1:0]             area,
  output logic [bds_pkg::QUO_W-1:0]     quo
);
  import bds_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;
  localparam int RW    = SUM_W + AREA_W;

  logic [SUM_W-1:0]    mem [DEPTH];
  logic [SUM_W-1:0]    rdata, sum;
  logic [ADDR_W-1:0]   addr_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [RW-1:0]       rem, dsh, div_area;

  // Read the column sum at accept and write it back in the following cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata    <= mem[rd_addr];
      addr_q   <= rd_addr;
      sample_q <= sample;
    end
    if (ctl.acc_en) begin
      mem[addr_q] <= sum;
    end
  end

  always_comb begin
    sum = ctl.first ? SUM_W'(sample_q) : rdata + SUM_W'(sample_q);
    div_area = (area == '0) ? RW'(1) : RW'(area);
    dsh = div_area << ctl.step;
  end

  // Restoring divide, one quotient bit per cycle, high bit first
  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      rem <= RW'(sum);
      quo <= '0;
    end else if (ctl.div_en) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo[ctl.step] <= 1'b1;
      end
    end
  end

endmodule

@@ hdl/bds_merge.sv @@
// Merge stage: gathers lane quotients and coordinates into the output register.
// Depends on bds_pkg.
module bds_merge #(
  parameter int LANES = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  logic [bds_pkg::QUO_W-1:0]        quo [LANES],
  input  logic [bds_pkg::CH_W-1:0]         ch,
  input  logic [bds_pkg::COORD_W-1:0]      x,
  input  logic [bds_pkg::COORD_W-1:0]      y,
  input  logic                             flast,
  output logic                             can_load,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [bds_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast
);
  import bds_pkg::*;

  logic [QUO_W-1:0] chan [OUT_CH];

  // Zero the channels that are not in use
  always_comb begin
    for (int c = 0; c < OUT_CH; c++) begin
      chan[c] = '0;
    end
    for (int c = 0; c < LANES; c++) begin
      if (3'(c) < 3'(ch)) begin
        chan[c] = quo[c];
      end
    end
  end

  assign can_load = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Hold the beat until it is taken
  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {y, x, chan[2], chan[1], chan[0]};
      m_axis_tlast <= flast;
    end
  end

endmodule

@@ hdl/box_filter_image_downscaler_unit.sv @@
// Box filter (area average) image downscaler: top level.
// Depends on bds_pkg, bds_pos, bds_lane and bds_merge.
//
// Source pixels enter in raster order on the s_axis side; each destination pixel leaves
// on m_axis once the last source pixel of its rectangle has been taken. One lane per
// channel keeps a column line of 32-bit sums in its own memory, read at accept and
// written back the next cycle, before the next pixel is taken. The pixel that closes a
// rectangle then runs a serial division (one quotient bit per cycle, all lanes at once)
// and loads the output register, waiting there while the output is stalled. After reset
// and after every configuration write the block works out the cell pitch before it
// takes pixels again; any write restarts the frame.
module box_filter_image_downscaler_unit #(
  parameter int MAX_WIDTH    = 4096,
  parameter int MAX_HEIGHT   = 4096,
  parameter int MAX_CHANNELS = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // sample_c0, sample_c1, sample_c2
  input  logic [bds_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_c0, out_c1, out_c2, out_x, out_y
  output logic [bds_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bds_pkg::IDX_W-1:0]       cfg_index,
  input  logic [bds_pkg::CFG_W-1:0]       cfg_data
);
  import bds_pkg::*;

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DW      = $clog2(MAX_DIM) + 1;
  localparam int ADDR_W  = $clog2(MAX_WIDTH);
  localparam int AREA_W  = 2 * DW;
  localparam int LANES   = (MAX_CHANNELS < OUT_CH) ? MAX_CHANNELS : OUT_CH;

  state_t state, state_next;

  logic               accept, busy, first, last, frame_end, can_load, load;
  logic [DW-1:0]      dst_col, dst_row;
  logic [AREA_W-1:0]  area, area_q;
  logic [CH_W-1:0]    ch;
  logic               first_q, last_q, flast_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [STEP_W-1:0]  step;
  lane_ctl_t          ctl;
  logic [QUO_W-1:0]   quo [LANES];

  assign accept = s_axis_tvalid && s_axis_tready;

  bds_pos #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_CHANNELS(MAX_CHANNELS),
    .DW          (DW)
  ) u_pos (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .adv      (accept),
    .busy     (busy),
    .first    (first),
    .last     (last),
    .frame_end(frame_end),
    .dst_col  (dst_col),
    .dst_row  (dst_row),
    .area     (area),
    .ch       (ch)
  );

  // Capture the pixel's rectangle info at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      first_q <= first;
      last_q  <= last;
      flast_q <= frame_end;
      area_q  <= area;
      x_q     <= COORD_W'(dst_col);
      y_q     <= COORD_W'(dst_row);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_ACC;
      ST_ACC:  state_next = last_q ? ST_DIV : ST_IDLE;
      ST_DIV:  if (step == '0) state_next = ST_EMIT;
      ST_EMIT: if (can_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready = (state == ST_IDLE) && !busy;
    ctl.acc_en    = (state == ST_ACC);
    ctl.first     = first_q;
    ctl.div_en    = (state == ST_DIV);
    ctl.step      = step;
    load          = (state == ST_EMIT) && can_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_ACC) begin
        step <= STEP_W'(QUO_W - 1);
      end else if (state == ST_DIV) begin
        step <= step - STEP_W'(1);
      end
    end
  end

  // Channel lanes
  for (genvar c = 0; c < LANES; c++) begin : g_lane
    bds_lane #(
      .ADDR_W(ADDR_W),
      .AREA_W(AREA_W)
    ) u_lane (
      .clk    (clk),
      .rd_en  (accept),
      .rd_addr(dst_col[ADDR_W-1:0]),
      .sample (s_axis_tdata[c*SAMPLE_W +: SAMPLE_W]),
      .ctl    (ctl),
      .area   (area_q),
      .quo    (quo[c])
    );
  end

  bds_merge #(
    .LANES(LANES)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .quo          (quo),
    .ch           (ch),
    .x            (x_q),
    .y            (y_q),
    .flast        (flast_q),
    .can_load     (can_load),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // A waiting result is never overwritten
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && m_axis_tvalid && !m_axis_tready) |=> (state == ST_EMIT))
    else $error("result dropped while output stalled");

  // A register write blocks input while the pitch is recomputed
  a_cfg_block: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> !s_axis_tready)
    else $error("input taken during setup");

  // Every accepted pixel goes through the accumulate cycle
  a_acc_follow: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_ACC))
    else $error("accumulate cycle skipped");

endmodule

@@ bench/bds_checker.sv @@
// Checker of the box filter downscaler: watches the pixel, result and register channels.
// Predicts every destination pixel and compares it field by field; depends on bds_pkg.
`timescale 1ns / 100ps

module bds_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [bds_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [bds_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                            m_axis_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [bds_pkg::IDX_W-1:0]       cfg_index,
  input  logic [bds_pkg::CFG_W-1:0]       cfg_data,
  output int                              errors,
  output int                              pending,
  output int                              results
);
  import bds_pkg::*;

  localparam int unsigned LINE_W  = 4096;
  localparam int unsigned LINE_H  = 4096;
  localparam int unsigned LINE_CH = 3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] c0;
    logic [SAMPLE_W-1:0] c1;
    logic [SAMPLE_W-1:0] c2;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic                last;
  } dst_pixel_t;

  dst_pixel_t  dst_pixels_due[$];

  // Register copies and scan position
  logic [CFG_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
  logic [CH_W-1:0]  chan_reg;
  int unsigned      line_sums [0:LINE_W*LINE_CH-1];
  int unsigned      scol, srow, dcol, drow, cstart, cend, rstart, rend;

  function automatic int unsigned limit_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned cell_bound(int unsigned d, int unsigned s, int unsigned n);
    return ((d + 1) * s) / n;
  endfunction

  function automatic int unsigned eff_sw();
    return limit_dim(src_w_reg, LINE_W);
  endfunction
  function automatic int unsigned eff_sh();
    return limit_dim(src_h_reg, LINE_H);
  endfunction
  function automatic int unsigned eff_dw();
    return limit_dim(dst_w_reg, eff_sw());
  endfunction
  function automatic int unsigned eff_dh();
    return limit_dim(dst_h_reg, eff_sh());
  endfunction

  task automatic rewind_frame();
    scol = 0; srow = 0; dcol = 0; drow = 0; cstart = 0; rstart = 0;
    cend = cell_bound(0, eff_sw(), eff_dw());
    rend = cell_bound(0, eff_sh(), eff_dh());
  endtask

  // Add one source pixel and queue the destination pixel it closes, if any
  task automatic take_pixel(logic [IN_DATA_W-1:0] px);
    int unsigned sw, sh, dw, dh, nch, area, idx;
    logic        open_cell, close_cell;
    logic [SAMPLE_W-1:0] avg [3];
    dst_pixel_t  exp_px;
    sw = eff_sw(); sh = eff_sh(); dw = eff_dw(); dh = eff_dh();
    nch = limit_dim(chan_reg, LINE_CH);
    open_cell  = (scol == cstart) && (srow == rstart);
    close_cell = (scol + 1 == cend) && (srow + 1 == rend);
    for (int c = 0; c < 3; c++) begin
      idx = dcol * LINE_CH + c;
      if (c < nch)
        line_sums[idx] = open_cell ? px[c*8 +: 8] : line_sums[idx] + px[c*8 +: 8];
    end
    if (close_cell) begin
      area = (cend - cstart) * (rend - rstart);
      if (area == 0) area = 1;
      for (int c = 0; c < 3; c++)
        avg[c] = (c < nch) ? SAMPLE_W'(line_sums[dcol * LINE_CH + c] / area) : '0;
      exp_px.c0 = avg[0];
      exp_px.c1 = avg[1];
      exp_px.c2 = avg[2];
      exp_px.x = COORD_W'(dcol);
      exp_px.y = COORD_W'(drow);
      exp_px.last = (dcol + 1 == dw) && (drow + 1 == dh);
      dst_pixels_due.push_back(exp_px);
    end
    // advance the scan position
    scol++;
    if (scol >= cend) begin
      dcol++;
      cstart = cend;
      cend = cell_bound(dcol, sw, dw);
    end
    if (scol >= sw || dcol >= dw) begin
      scol = 0; dcol = 0; cstart = 0;
      cend = cell_bound(0, sw, dw);
      srow++;
      if (srow >= rend) begin
        drow++;
        rstart = rend;
        rend = cell_bound(drow, sh, dh);
      end
      if (srow >= sh || drow >= dh) rewind_frame();
    end
  endtask

  task automatic check_pixel();
    dst_pixel_t got, exp_px;
    got.c0 = m_axis_tdata[7:0];
    got.c1 = m_axis_tdata[15:8];
    got.c2 = m_axis_tdata[23:16];
    got.x = m_axis_tdata[35:24];
    got.y = m_axis_tdata[47:36];
    got.last = m_axis_tlast;
    if (dst_pixels_due.size() == 0) begin
      $display("%0t: unexpected result beat x=%0d y=%0d", $time, got.x, got.y);
      errors++;
      return;
    end
    exp_px = dst_pixels_due.pop_front();
    if (got != exp_px) begin
      $display("%0t: mismatch expected c0=%h c1=%h c2=%h x=%0d y=%0d last=%b", $time,
               exp_px.c0, exp_px.c1, exp_px.c2, exp_px.x, exp_px.y, exp_px.last);
      $display("%0t:          actual   c0=%h c1=%h c2=%h x=%0d y=%0d last=%b", $time,
               got.c0, got.c1, got.c2, got.x, got.y, got.last);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
    results = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      src_w_reg = 1; src_h_reg = 1; dst_w_reg = 1; dst_h_reg = 1;
      chan_reg = 3;
      rewind_frame();
      dst_pixels_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_pixel();
        results++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SRC_WIDTH:  src_w_reg = cfg_data;
          REG_SRC_HEIGHT: src_h_reg = cfg_data;
          REG_DST_WIDTH:  dst_w_reg = cfg_data;
          REG_DST_HEIGHT: dst_h_reg = cfg_data;
          REG_CHANNELS:   chan_reg = cfg_data[CH_W-1:0];
          default: ;
        endcase
        rewind_frame();
      end
      if (s_axis_tvalid && s_axis_tready) take_pixel(s_axis_tdata);
    end
    pending <= dst_pixels_due.size();
  end

endmodule

@@ bench/tb_box_filter_image_downscaler_unit.sv @@
// Top of the downscaler testbench: clock, reset, pixel and register stimulus, verdict.
// Depends on bds_pkg, box_filter_image_downscaler_unit and bds_checker.
`timescale 1ns / 100ps

module tb_box_filter_image_downscaler_unit;
  import bds_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 40;

  logic                  clk, rst;
  logic                  s_axis_tvalid, s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid, m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid, cfg_ready;
  logic [IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  int   errors, pending, results;
  int   pixels_sent, settings_used;
  int   cycles;
  logic s_beat, cfg_beat;
  logic tx_steady, rx_steady, hold_toggle, hold_seen;
  int   hold_left;

  box_filter_image_downscaler_unit i_dut (.*);

  bds_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Handshakes seen at the last rising edge
  always @(posedge clk) begin
    s_beat   <= s_axis_tvalid & s_axis_tready;
    cfg_beat <= cfg_valid & cfg_ready;
  end

  // Result side: random stalls, steady stretches, and one long hold-off
  always @(negedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rx_steady || ($urandom_range(99) >= 25);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run limit reached, %0d results still due", $time, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
    if (!tx_steady && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {c2, c1, c0};
    do @(negedge clk); while (!s_beat);
    pixels_sent++;
  endtask

  task automatic send_noise(int count);
    for (int i = 0; i < count; i++)
      send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
  endtask

  // Let every due result out, then give the block time to finish silent pixels
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Drop valid for one cycle after the beat so back-to-back writes stay apart
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_beat);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(int sw, int sh, int dw, int dh, int nch);
    drain();
    write_reg(REG_SRC_WIDTH, CFG_W'(sw));
    write_reg(REG_SRC_HEIGHT, CFG_W'(sh));
    write_reg(REG_DST_WIDTH, CFG_W'(dw));
    write_reg(REG_DST_HEIGHT, CFG_W'(dh));
    write_reg(REG_CHANNELS, CFG_W'(nch));
    settings_used++;
  endtask

  initial begin
    int sw, sh, dw, dh, nch, frame_px;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    m_axis_tready = 1'b0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_toggle = 1'b0;
    hold_seen = 1'b0;
    hold_left = 0;
    cycles = 0;
    pixels_sent = 0;
    settings_used = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Reset sizes: every pixel is its own destination pixel
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'ha5, 8'h5a, 8'h3c);

    // Channel count of zero acts as one; full-scale sums
    set_geometry(4, 2, 2, 1, 0);
    repeat (8) send_pixel(8'hff, 8'hff, 8'hff);

    // Unused register index, then an upscale request clamped to the source
    drain();
    write_reg(3'd5, 13'h1fff);
    set_geometry(2, 1, 9, 9, 2);
    send_pixel(8'h01, 8'h80, 8'hff);
    send_pixel(8'hfe, 8'h7f, 8'h00);

    // Oversize width, zero destination, channel field masked; cut the frame short
    set_geometry(8191, 1, 0, 1, 7);
    send_noise(6);
    // Widest line at ratio one
    set_geometry(4096, 1, 8191, 1, 3);
    send_noise(4);

    // Long hold-off on the result side while pixels keep coming
    set_geometry(8, 8, 8, 8, 3);
    hold_toggle = ~hold_toggle;
    send_noise(64);

    // Random geometries, mostly whole frames; the first one runs with no idling
    while (pixels_sent < 1250) begin
      sw = ($urandom_range(9) == 0) ? $urandom_range(64, 150) : $urandom_range(1, 24);
      sh = (sw > 64) ? $urandom_range(1, 2) : $urandom_range(1, 16);
      dw = $urandom_range(0, sw + 2);
      dh = $urandom_range(0, sh + 2);
      nch = $urandom_range(0, 3);
      set_geometry(sw, sh, dw, dh, nch);
      tx_steady = (settings_used % 7 == 6);
      rx_steady = tx_steady;
      frame_px = sw * sh;
      repeat ($urandom_range(1, 2)) send_noise(frame_px);
      if ($urandom_range(3) == 0) send_noise($urandom_range(1, frame_px));
      tx_steady = 1'b0;
      rx_steady = 1'b0;
    end

    drain();
    $display("Sent %0d source pixels over %0d register settings; %0d destination pixels checked.",
             pixels_sent, settings_used, results);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
